>>> rtl/zrle_pkg.sv
// types, constants and helpers shared by the zigzag run-length encoder
package zrle_pkg;

	localparam int unsigned CoefWidth = 12;
	localparam int unsigned BlockSize = 64;
	localparam int unsigned PosWidth  = 6;
	localparam logic [PosWidth-1:0] LastPos = 6'd63;
	localparam logic [3:0] MaxRun = 4'd15;
	localparam logic [3:0] MaxCategory = 4'd15;

	// zigzag position to raster position
	localparam logic [PosWidth-1:0] ZzToRaster [BlockSize] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	typedef struct packed {
		logic signed [CoefWidth-1:0] coef;
		logic [PosWidth-1:0]         raster_index;
		logic                        end_of_block;
	} in_t;

	typedef struct packed {
		logic [3:0]                  zero_run;
		logic [3:0]                  category;
		logic signed [CoefWidth-1:0] value;
		logic                        last;
	} out_t;

	// one queued operation for the back end: a buffer write, optionally followed by a walk
	typedef struct packed {
		logic [CoefWidth-1:0] coef;
		logic [PosWidth-1:0]  addr;
		logic                 walk;
	} op_t;

	// bit length of the magnitude, saturated at 15
	function automatic logic [3:0] category_of(logic [CoefWidth-1:0] v);
		logic [CoefWidth-1:0] mag;
		logic [4:0] n;
		mag = v[CoefWidth-1] ? (~v + CoefWidth'(1)) : v;
		n = '0;
		for (int i = 0; i < int'(CoefWidth); i++) begin
			if (mag[i]) begin
				n = 5'(i + 1);
			end
		end
		return (n > {1'b0, MaxCategory}) ? MaxCategory : n[3:0];
	endfunction

endpackage

>>> rtl/zrle_ram.sv
// generic single-write, single-read RAM with registered read data
module zrle_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/zrle_fifo.sv
// small synchronous queue with push/full and pop/empty sides
module zrle_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       pop,
	output logic                       empty,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/zrle_front.sv
// front end: takes coefficients and queues buffer write / walk operations
module zrle_front #(
	parameter int unsigned CMD_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  zrle_pkg::in_t       item,
	input  logic                op_pop,
	output logic                op_empty,
	output zrle_pkg::op_t       op
);

	zrle_pkg::op_t op_in;
	logic [$bits(zrle_pkg::op_t)-1:0] op_raw;

	// every item is a buffer write; the end-of-block item also launches a walk
	always_comb begin
		op_in.coef = item.coef;
		op_in.addr = item.raster_index;
		op_in.walk = item.end_of_block;
	end

	assign op = zrle_pkg::op_t'(op_raw);

	zrle_fifo #(
		.WIDTH ($bits(zrle_pkg::op_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_data (op_in),
		.pop     (op_pop),
		.empty   (op_empty),
		.rd_data (op_raw),
		.count   ()
	);

endmodule

>>> rtl/zrle_back.sv
// back end: coefficient buffer, zigzag walk and triple generation
module zrle_back #(
	parameter int unsigned RES_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_empty,
	input  zrle_pkg::op_t                  op,
	output logic                           op_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
	input  logic                           res_full,
	output logic                           res_push,
	output zrle_pkg::out_t                 res
);

	localparam int unsigned CW = $clog2(RES_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q;
	logic [zrle_pkg::PosWidth-1:0] pos_q, pos_s1;
	logic valid_s1;
	logic [3:0] pend_q;
	logic issue;
	logic emit;
	logic [zrle_pkg::CoefWidth-1:0] rd_data;
	logic [CW:0] inflight;

	assign op_pop = (state_q == ST_IDLE) && !op_empty;

	// a read is issued only if its possible result is sure to find room
	assign inflight = {1'b0, res_count} + (CW + 1)'(valid_s1);
	assign issue    = (state_q == ST_WALK) && (inflight < (CW + 1)'(RES_DEPTH));

	zrle_ram #(
		.WIDTH (zrle_pkg::CoefWidth),
		.DEPTH (zrle_pkg::BlockSize)
	) u_coef_ram (
		.clk   (clk),
		.we    (op_pop),
		.waddr (op.addr),
		.wdata (op.coef),
		.re    (issue),
		.raddr (zrle_pkg::ZzToRaster[pos_q]),
		.rdata (rd_data)
	);

	assign emit = valid_s1 && ((pend_q == zrle_pkg::MaxRun) || (rd_data != '0)
		|| (pos_s1 == zrle_pkg::LastPos));

	assign res_push = emit;
	always_comb begin
		res.zero_run = pend_q;
		res.category = zrle_pkg::category_of(rd_data);
		res.value    = rd_data;
		res.last     = (pos_s1 == zrle_pkg::LastPos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
			pend_q   <= '0;
		end else begin
			valid_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (op_pop && op.walk) begin
						state_q <= ST_WALK;
						pos_q   <= '0;
					end
				end
				ST_WALK: begin
					if (issue) begin
						if (pos_q == zrle_pkg::LastPos) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (valid_s1) begin
				pend_q <= emit ? 4'd0 : pend_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1 <= pos_q;
		end
	end

	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into a full result queue");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= zrle_pkg::MaxRun)
		else $error("pending zero run beyond its limit");

	a_read_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_WALK))
		else $error("buffer read data valid without a walk");

	a_walk_ends_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && issue && pos_q == zrle_pkg::LastPos) |=> state_q == ST_IDLE)
		else $error("walk did not stop after the last zigzag position");

endmodule

>>> rtl/zigzag_run_length_encoder_core.sv
// Zigzag run-length encoder for 8x8 blocks of quantized coefficients.
// Coefficients are accepted one per cycle while the command queue of CMD_DEPTH
// entries is not full, and written into a 64-entry buffer at their raster
// position, one write per cycle while the back end is idle. The item flagged
// end_of_block starts a walk of the buffer in zigzag order: one buffer read per
// cycle while the result queue has room, during which the back end performs no
// writes and incoming coefficients only fill the command queue. A full block
// thus takes 64 writes plus 64 reads at the back end; each triple is formed
// from the registered buffer read data and then passes through the result queue.
// Buffer entries keep their value across blocks; the buffer is not cleared at
// reset, so every position must be written before the first walk reads it.
module zigzag_run_length_encoder_core #(
	parameter int unsigned CMD_DEPTH = 4,
	parameter int unsigned RES_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  zrle_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output zrle_pkg::out_t result
);

	zrle_pkg::op_t op;
	logic op_pop, op_empty;
	logic res_push, res_full;
	logic [$clog2(RES_DEPTH+1)-1:0] res_count;
	zrle_pkg::out_t res;
	logic [$bits(zrle_pkg::out_t)-1:0] res_raw;

	zrle_front #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.op_pop   (op_pop),
		.op_empty (op_empty),
		.op       (op)
	);

	zrle_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_empty  (op_empty),
		.op        (op),
		.op_pop    (op_pop),
		.res_count (res_count),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	zrle_fifo #(
		.WIDTH ($bits(zrle_pkg::out_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.wr_data (res),
		.pop     (pop),
		.empty   (empty),
		.rd_data (res_raw),
		.count   (res_count)
	);

	assign result = zrle_pkg::out_t'(res_raw);

endmodule

>>> bench/zrle_triple_checker.sv
// checker: predicts zigzag run-length triples from the coefficient transfers and compares them
module zrle_triple_checker
	import zrle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  in_t  item,
	input  logic pop,
	input  logic empty,
	input  out_t result,
	output int   fail_count,
	output int   pending,
	output int   n_coefs,
	output int   n_walks,
	output int   n_triples
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [PosWidth-1:0]  zz_order [BlockSize];
	logic [CoefWidth-1:0] coef_image [BlockSize];
	out_t                 expected_triples [$];

	initial begin
		fail_count = 0;
		pending = 0;
		n_coefs = 0;
		n_walks = 0;
		n_triples = 0;
		build_zigzag();
	end

	// walk the anti-diagonals, alternating direction
	function automatic void build_zigzag();
		int p;
		int lo;
		int hi;
		int row;
		p = 0;
		for (int s = 0; s < 15; s++) begin
			lo = (s > 7) ? s - 7 : 0;
			hi = (s < 7) ? s : 7;
			for (int k = 0; k <= hi - lo; k++) begin
				row = (s % 2 == 0) ? hi - k : lo + k;
				zz_order[p] = PosWidth'(row * 8 + s - row);
				p++;
			end
		end
	endfunction

	function automatic logic [3:0] bit_length(logic signed [CoefWidth-1:0] v);
		int mag;
		int n;
		mag = (v < 0) ? -int'(v) : int'(v);
		n = 0;
		while (mag != 0) begin
			mag = mag >> 1;
			n++;
		end
		return (n > 15) ? 4'd15 : 4'(n);
	endfunction

	task automatic walk_block();
		int run;
		out_t t;
		logic [CoefWidth-1:0] v;
		run = 0;
		for (int p = 0; p < int'(BlockSize); p++) begin
			v = coef_image[zz_order[p]];
			if (run == int'(MaxRun) || v != '0 || p == int'(LastPos)) begin
				t.zero_run = 4'(run);
				t.category = bit_length(v);
				t.value = v;
				t.last = (p == int'(LastPos));
				expected_triples.insert(expected_triples.size(), t);
				run = 0;
			end else begin
				run++;
			end
		end
	endtask

	task automatic report(input string what);
		if (fail_count < 20) begin
			$display("%0t mismatch: %s", $time, what);
		end
		fail_count++;
	endtask

	task automatic check_triple();
		out_t want;
		if (expected_triples.size() == 0) begin
			report($sformatf("triple with nothing waiting: run %0d cat %0d value %0d last %0b",
				result.zero_run, result.category, result.value, result.last));
		end else begin
			want = expected_triples.pop_front();
			if (result.zero_run != want.zero_run)
				report($sformatf("zero_run %0d, want %0d", result.zero_run, want.zero_run));
			if (result.category != want.category)
				report($sformatf("category %0d, want %0d", result.category, want.category));
			if (result.value != want.value)
				report($sformatf("value %0d, want %0d", result.value, want.value));
			if (result.last != want.last)
				report($sformatf("last %0b, want %0b", result.last, want.last));
		end
		n_triples++;
	endtask

	// result transfer checked before the coefficient transfer of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				check_triple();
			end
			if (push && !full) begin
				coef_image[item.raster_index] = item.coef;
				n_coefs++;
				if (item.end_of_block) begin
					walk_block();
					n_walks++;
				end
			end
			pending = expected_triples.size();
		end
	end

endmodule

>>> bench/tb_zigzag_run_length_encoder_core.sv
// testbench top: clock, reset, coefficient stimulus, watchdog and verdict
module tb_zigzag_run_length_encoder_core;

	timeunit 1ns;
	timeprecision 1ps;

	import zrle_pkg::*;

	localparam int IdleLimit   = 4000;
	localparam int DrainCycles = 100;
	localparam int RandomItems = 360;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	in_t  item = '0;
	logic full;
	logic empty;
	out_t result;

	int fail_count;
	int pending;
	int n_coefs;
	int n_walks;
	int n_triples;
	int n_sent = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;

	zigzag_run_length_encoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	zrle_triple_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.pop        (pop),
		.empty      (empty),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.n_coefs    (n_coefs),
		.n_walks    (n_walks),
		.n_triples  (n_triples)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		pop <= steady || ($urandom_range(99) >= 22);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles == IdleLimit) begin
				$display("no transfer for %0d cycles", IdleLimit);
				$display("FAIL zigzag_run_length_encoder_core");
				$finish;
			end
		end
	end

	// returns after the transfer edge, so the next call sets push only once per step
	task automatic push_coef(input int coef, input int idx, input bit eob);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 22) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{coef: CoefWidth'(coef), raster_index: PosWidth'(idx), end_of_block: eob};
		@(posedge clk);
		while (full) @(posedge clk);
		n_sent++;
		steady = (n_sent >= 250 && n_sent < 350);
	endtask

	// mostly zeros and small values, as after quantisation, with some full-range words
	function automatic int pick_coef();
		int r;
		int m;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) begin
			m = (r < 80) ? $urandom_range(15, 1) : $urandom_range(255, 16);
			return $urandom_range(1) ? -m : m;
		end
		return int'($signed(CoefWidth'($urandom)));
	endfunction

	task automatic full_block();
		int start;
		int stride;
		start = $urandom_range(63);
		stride = 2 * $urandom_range(31) + 1;
		for (int k = 0; k < 64; k++) begin
			push_coef(pick_coef(), (start + k * stride) % 64, k == 63);
		end
	endtask

	task automatic sparse_block();
		int k;
		k = $urandom_range(8, 1);
		for (int i = 0; i < k; i++) begin
			push_coef(pick_coef(), $urandom_range(1) ? $urandom_range(15) : $urandom_range(63),
				i == k - 1);
		end
	endtask

	initial begin
		int r;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// whole block of zeros: runs of fifteen and a zero last triple
		for (int i = 0; i < 64; i++) begin
			push_coef(0, i, i == 63);
		end
		push_coef(-2048, 0, 1'b0);
		push_coef(2047, 63, 1'b0);
		push_coef(5, 1, 1'b0);
		// same position twice, later write wins
		push_coef(-1, 1, 1'b1);
		// untouched entries stay from the previous block
		push_coef(1, 8, 1'b1);
		// nonzero right after fifteen pending zeros
		push_coef(300, 26, 1'b1);
		push_coef(0, 26, 1'b0);
		push_coef(-2048, 63, 1'b1);
		push_coef(0, 0, 1'b0);
		push_coef(0, 1, 1'b0);
		push_coef(0, 8, 1'b1);

		r = n_sent;
		while (n_sent - r < RandomItems) begin
			case ($urandom_range(99)) inside
				[0:7]: push_coef(pick_coef(), $urandom_range(63), 1'b0);
				[8:11]: full_block();
				default: sparse_block();
			endcase
		end

		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("covered %0d coefficient transfers and %0d block walks", n_coefs, n_walks);
		$display("compared %0d triples, %0d mismatches", n_triples, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS zigzag_run_length_encoder_core");
		end else begin
			$display("FAIL zigzag_run_length_encoder_core");
		end
		$finish;
	end

endmodule
